@@ design/cfr_pkg.sv @@
package cfr_pkg;

  // Image geometry.
  localparam int FACE_WIDTH   = 8192;
  localparam int FACE_LOG2    = 13;
  localparam int FACE_HALF    = FACE_WIDTH / 2;
  localparam int SOURCE_WIDTH = 16384;
  localparam int COL_W        = 13;
  localparam int SX_W         = 14;
  localparam int SY_W         = 13;
  localparam int SX_MAX       = SOURCE_WIDTH - 1;
  localparam int SY_MAX       = SOURCE_WIDTH / 2 - 1;

  // Fixed-point formats.
  localparam int Q24      = 24;
  localparam int FRAC     = 20;
  localparam int UV_SHIFT = Q24 - FACE_LOG2;
  localparam int DIFF_W   = COL_W + 2;
  localparam int XW       = 30;
  localparam int ZW       = 29;
  localparam int AW       = 32;
  localparam int PROD_W   = 41;

  localparam int CORDIC_STEPS = 27;
  localparam int STEP_W       = 5;

  // Degrees to source pixels: both axes divide by 180*2^20/(SOURCE_WIDTH/2).
  // That divisor is 2^9 * 45; the 45 is done by a reciprocal multiply.
  localparam int SCALE_SHIFT = 9;
  localparam int LW          = 20;
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 32;
  localparam int MUL_W       = LW + RECIP_W;
  localparam int QW          = 15;
  localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;

  localparam logic signed [XW-1:0] ONE_Q24  = 30'sd16777216;
  localparam logic signed [XW-1:0] GAIN_Q24 = 30'sd27628053;

  localparam logic signed [AW-1:0] DEG_90  = 32'sd94371840;
  localparam logic signed [AW-1:0] DEG_180 = 32'sd188743680;
  localparam logic signed [AW-1:0] DEG_360 = 32'sd377487360;
  localparam logic signed [ZW-1:0] ZDEG_90 = 29'sd94371840;

  // Face kinds.
  localparam logic [1:0] KIND_EQUATOR = 2'd0;
  localparam logic [1:0] KIND_NORTH   = 2'd1;
  localparam logic [1:0] KIND_SOUTH   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_FACE_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LON = 2'd1;

  localparam logic signed [ZW-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
    29'sd1876857, 29'sd938658, 29'sd469357, 29'sd234682, 29'sd117342,
    29'sd58671, 29'sd29335, 29'sd14668, 29'sd7334, 29'sd3667, 29'sd1833,
    29'sd917, 29'sd458, 29'sd229, 29'sd115, 29'sd57, 29'sd29, 29'sd14,
    29'sd7, 29'sd4, 29'sd2, 29'sd1
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // Carried alongside the first CORDIC pair.
  typedef struct packed {
    logic                 centre;
    logic                 rlt;
    logic                 dz;
    logic                 npos;
    logic                 nneg;
    logic signed [XW-1:0] yb;
  } side_a_t;

  // Carried alongside the latitude CORDIC.
  typedef struct packed {
    logic                 centre;
    logic                 rlt;
    logic signed [ZW-1:0] lon;
  } side_b_t;

  // One vectoring micro-rotation toward the x axis.
  function automatic vec_t vec_step(vec_t a, logic [STEP_W-1:0] k);
    vec_t r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = a.x >>> k;
    ys = a.y >>> k;
    r  = a;
    if (!a.y[XW-1]) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + ATAN_Q20[k];
    end else begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - ATAN_Q20[k];
    end
    return r;
  endfunction

endpackage

@@ design/cfr_prep.sv @@
module cfr_prep
  import cfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [COL_W-1:0] in_column,
  input  logic [COL_W-1:0] in_row,
  input  logic [1:0]       face_kind,
  output logic             vld_r,
  output vec_t             a_r,
  output vec_t             b_r,
  output side_a_t          side_r
);

  logic signed [DIFF_W-1:0] cdiff;
  logic signed [DIFF_W-1:0] rdiff;
  logic signed [XW-1:0]     u;
  logic signed [XW-1:0]     v;
  logic signed [XW-1:0]     au;
  logic signed [XW-1:0]     av;
  logic signed [XW-1:0]     xp;
  logic signed [XW-1:0]     d;
  logic signed [XW-1:0]     n;
  logic signed [XW-1:0]     dd;
  logic signed [PROD_W-1:0] prod;
  logic                     polar;
  logic                     north;
  logic                     rlt;
  logic                     rle;
  vec_t                     a_nxt;
  vec_t                     b_nxt;
  side_a_t                  side_nxt;

  always_comb begin
    cdiff = $signed({1'b0, in_column, 1'b0}) - $signed(DIFF_W'(FACE_WIDTH));
    rdiff = $signed({1'b0, in_row, 1'b0}) - $signed(DIFF_W'(FACE_WIDTH));
    u     = XW'(cdiff) <<< UV_SHIFT;
    v     = XW'(rdiff) <<< UV_SHIFT;
    au    = u[XW-1] ? -u : u;
    av    = v[XW-1] ? -v : v;
    polar = (face_kind == KIND_NORTH) || (face_kind == KIND_SOUTH);
    north = (face_kind == KIND_NORTH);
    rlt   = in_row < COL_W'(FACE_HALF);
    rle   = in_row <= COL_W'(FACE_HALF);

    // Polar longitude is atan(x'/d) with d made non-negative first.
    xp = (north ? rle : rlt) ? -u : u;
    d  = north ? -v : v;
    n  = d[XW-1] ? -xp : xp;
    dd = d[XW-1] ? -d : d;

    prod = PROD_W'(rdiff) * PROD_W'(GAIN_Q24);

    if (polar) begin
      a_nxt       = '{x: au, y: av, z: '0};
      side_nxt.yb = GAIN_Q24;
    end else begin
      a_nxt       = '{x: ONE_Q24, y: u, z: '0};
      side_nxt.yb = XW'(prod >>> (Q24 - UV_SHIFT));
    end
    b_nxt           = '{x: dd, y: n, z: '0};
    side_nxt.centre = (in_column == COL_W'(FACE_HALF)) && (in_row == COL_W'(FACE_HALF));
    side_nxt.rlt    = rlt;
    side_nxt.dz     = (dd == '0);
    side_nxt.npos   = !n[XW-1] && (n != '0);
    side_nxt.nneg   = n[XW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

@@ design/cfr_vec_dual.sv @@
module cfr_vec_dual
  import cfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_vld,
  input  vec_t    in_a,
  input  vec_t    in_b,
  input  side_a_t in_side,
  output logic    out_vld,
  output vec_t    out_a,
  output vec_t    out_b,
  output side_a_t out_side
);

  logic [CORDIC_STEPS-1:0] vld_r;
  vec_t                    a_r    [CORDIC_STEPS];
  vec_t                    b_r    [CORDIC_STEPS];
  side_a_t                 side_r [CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORDIC_STEPS-2:0], in_vld};
    end
  end

  // One micro-rotation of each lane per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]    <= vec_step(in_a, '0);
      b_r[0]    <= vec_step(in_b, '0);
      side_r[0] <= in_side;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        a_r[k]    <= vec_step(a_r[k-1], STEP_W'(k));
        b_r[k]    <= vec_step(b_r[k-1], STEP_W'(k));
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[CORDIC_STEPS-1];
  assign out_a    = a_r[CORDIC_STEPS-1];
  assign out_b    = b_r[CORDIC_STEPS-1];
  assign out_side = side_r[CORDIC_STEPS-1];

endmodule

@@ design/cfr_vec_lat.sv @@
module cfr_vec_lat
  import cfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    in_vld,
  input  vec_t    in_a,
  input  side_b_t in_side,
  output logic    out_vld,
  output vec_t    out_a,
  output side_b_t out_side
);

  logic [CORDIC_STEPS-1:0] vld_r;
  vec_t                    a_r    [CORDIC_STEPS];
  side_b_t                 side_r [CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORDIC_STEPS-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]    <= vec_step(in_a, '0);
      side_r[0] <= in_side;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        a_r[k]    <= vec_step(a_r[k-1], STEP_W'(k));
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[CORDIC_STEPS-1];
  assign out_a    = a_r[CORDIC_STEPS-1];
  assign out_side = side_r[CORDIC_STEPS-1];

endmodule

@@ design/cfr_post.sv @@
module cfr_post
  import cfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  vec_t                    in_a,
  input  side_b_t                 in_side,
  input  logic [1:0]              face_kind,
  input  logic signed [CFG_W-1:0] center_lon,
  output logic                    out_valid,
  output logic [SX_W-1:0]         out_src_x,
  output logic [SY_W-1:0]         out_src_y
);

  logic [3:0]              vld_r;
  logic                    out_valid_r;
  logic signed [AW-1:0]    lat1_r, lon1_r, lat2_r, lon2_r;
  logic signed [AW-1:0]    lat1_nxt, lon1_nxt, lat2_nxt, lon2_nxt;
  logic signed [AW-1:0]    ysum, xsum;
  logic [LW-1:0]           ly_r, lx_r, ly_nxt, lx_nxt;
  logic [MUL_W-1:0]        py_r, px_r;
  logic [QW-1:0]           qy, qx;
  logic [SX_W-1:0]         sx_r, sx_nxt;
  logic [SY_W-1:0]         sy_r, sy_nxt;
  logic signed [AW-1:0]    latz, lonz, clon;
  logic                    polar;
  logic                    north;

  always_comb begin
    polar = (face_kind == KIND_NORTH) || (face_kind == KIND_SOUTH);
    north = (face_kind == KIND_NORTH);
    latz  = AW'(in_a.z);
    lonz  = AW'(in_side.lon);
    clon  = AW'(center_lon) <<< FRAC;

    // Stage 1: pick latitude and longitude per face kind, add the offset.
    if (in_side.centre) begin
      lat1_nxt = polar ? (north ? DEG_90 : -DEG_90) : '0;
      lon1_nxt = clon;
    end else begin
      lat1_nxt = (polar && !north) ? -latz : latz;
      lon1_nxt = ((polar && in_side.rlt) ? (DEG_180 - lonz) : lonz) + clon;
    end

    // Stage 2: fold back into range once.
    if (lat1_r > DEG_90) begin
      lat2_nxt = DEG_180 - lat1_r;
    end else if (lat1_r < -DEG_90) begin
      lat2_nxt = -DEG_180 - lat1_r;
    end else begin
      lat2_nxt = lat1_r;
    end
    if (lon1_r > DEG_180) begin
      lon2_nxt = lon1_r - DEG_360;
    end else if (lon1_r < -DEG_180) begin
      lon2_nxt = lon1_r + DEG_360;
    end else begin
      lon2_nxt = lon1_r;
    end

    // Stage 3: shift to a non-negative offset and drop the power-of-two part.
    ysum   = lat2_r + DEG_90;
    xsum   = lon2_r + DEG_180;
    ly_nxt = ysum[AW-1] ? '0 : ysum[SCALE_SHIFT +: LW];
    lx_nxt = xsum[AW-1] ? '0 : xsum[SCALE_SHIFT +: LW];

    // Output stage: quotient by 45, saturated to the image edge.
    qy     = py_r[RECIP_SHIFT +: QW];
    qx     = px_r[RECIP_SHIFT +: QW];
    sy_nxt = (qy > QW'(SY_MAX)) ? SY_W'(SY_MAX) : qy[SY_W-1:0];
    sx_nxt = (qx > QW'(SX_MAX)) ? SX_W'(SX_MAX) : qx[SX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[2:0], in_vld};
      out_valid_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat1_r <= lat1_nxt;
      lon1_r <= lon1_nxt;
      lat2_r <= lat2_nxt;
      lon2_r <= lon2_nxt;
      ly_r   <= ly_nxt;
      lx_r   <= lx_nxt;
      py_r   <= MUL_W'(ly_r) * MUL_W'(RECIP_45);
      px_r   <= MUL_W'(lx_r) * MUL_W'(RECIP_45);
      sy_r   <= sy_nxt;
      sx_r   <= sx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_src_x = sx_r;
  assign out_src_y = sy_r;

endmodule

@@ design/cube_face_to_equirect_remap.sv @@
// Cube-face to equirectangular coordinate remap.
//
// Each input item is one cube-face pixel (in_column, in_row); each output item
// is the pixel (out_src_x, out_src_y) of the equirectangular source image that
// it is taken from. Both channels use valid/ready; exactly one output item is
// produced for every input item, in order.
// The face is chosen by two registers written through the cfg_ port: index 0
// selects an equatorial, north or south face, index 1 gives the longitude
// offset of the face centre in whole degrees. Write them only while no item is
// in flight; the normalize, latitude-input and post stages read them directly.
// The datapath is a 60-stage pipeline: one stage to normalize the pixel, two
// chained 27-stage vectoring CORDIC units (one micro-rotation per stage), three
// stages of angle fold and offset, one multiply stage and the output register.
// One item is taken per cycle while the receiver keeps up.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. Reset (rst_n, synchronous) clears
// all valid bits and sets the registers to an equatorial face at longitude 0.
module cube_face_to_equirect_remap
  import cfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COL_W-1:0]     in_column,
  input  logic [COL_W-1:0]     in_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SX_W-1:0]      out_src_x,
  output logic [SY_W-1:0]      out_src_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [1:0]              face_kind_r;
  logic signed [CFG_W-1:0] center_lon_r;
  logic                    adv;

  logic    p_vld;
  vec_t    p_a, p_b;
  side_a_t p_side;

  logic    c1_vld;
  vec_t    c1_a, c1_b;
  side_a_t c1_side;

  vec_t    lat_in;
  side_b_t lat_side_in;

  logic    c2_vld;
  vec_t    c2_a;
  side_b_t c2_side;

  // The pipeline moves as a whole whenever the output register can take a value.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_kind_r  <= KIND_EQUATOR;
      center_lon_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_KIND:  face_kind_r  <= cfg_wdata[1:0];
        CFG_CENTER_LON: center_lon_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfr_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_column (in_column),
    .in_row    (in_row),
    .face_kind (face_kind_r),
    .vld_r     (p_vld),
    .a_r       (p_a),
    .b_r       (p_b),
    .side_r    (p_side)
  );

  // Lane a: longitude and magnitude (equatorial) or radial magnitude (polar).
  // Lane b: polar longitude as atan of the signed ratio.
  cfr_vec_dual u_vec_dual (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p_vld),
    .in_a     (p_a),
    .in_b     (p_b),
    .in_side  (p_side),
    .out_vld  (c1_vld),
    .out_a    (c1_a),
    .out_b    (c1_b),
    .out_side (c1_side)
  );

  // The latitude unit starts from the magnitude found by lane a. The longitude
  // is settled here and rides along: a zero polar denominator gives plus or
  // minus 90 degrees by the sign of the numerator, or zero if that is zero.
  always_comb begin
    lat_in             = '{x: c1_a.x, y: c1_side.yb, z: '0};
    lat_side_in.centre = c1_side.centre;
    lat_side_in.rlt    = c1_side.rlt;
    if ((face_kind_r != KIND_NORTH) && (face_kind_r != KIND_SOUTH)) begin
      lat_side_in.lon = c1_a.z;
    end else if (c1_side.dz) begin
      lat_side_in.lon = c1_side.npos ? ZDEG_90 : (c1_side.nneg ? -ZDEG_90 : '0);
    end else begin
      lat_side_in.lon = c1_b.z;
    end
  end

  cfr_vec_lat u_vec_lat (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c1_vld),
    .in_a     (lat_in),
    .in_side  (lat_side_in),
    .out_vld  (c2_vld),
    .out_a    (c2_a),
    .out_side (c2_side)
  );

  cfr_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (c2_vld),
    .in_a       (c2_a),
    .in_side    (c2_side),
    .face_kind  (face_kind_r),
    .center_lon (center_lon_r),
    .out_valid  (out_valid),
    .out_src_x  (out_src_x),
    .out_src_y  (out_src_y)
  );

endmodule
